// File: src/mbd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbd_pkg
// Shared types, constants and lane arithmetic of the mip chain generator.
// ---------------------------------------------------------------------------
package mbd_pkg;

    localparam int CFG_W   = 13;
    localparam int PIX_W   = 32;
    localparam int SUM_W   = 36;
    localparam int LANE_W  = 9;
    localparam int LVL_W   = 4;
    localparam int COORD_W = 11;
    localparam int IDX_W   = 2;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_LEVELS = 13;

    localparam logic [CFG_W-1:0] RESET_SIZE = 13'd4096;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        CELL_IDLE,
        CELL_WAIT,
        CELL_EMIT
    } cell_state_t;

    // pixel travelling up the chain with the geometry of the level it enters
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pix;
        logic [CFG_W-1:0] cw;
        logic [CFG_W-1:0] ch;
        logic [CFG_W-1:0] base;
        logic [LVL_W-1:0] levels;
    } token_t;

    typedef struct packed {
        logic [CFG_W-1:0] col;
        logic [CFG_W-1:0] row;
    } peek_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [CFG_W-1:0] addr;
        logic [SUM_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic               valid;
        logic [LVL_W-1:0]   mip_level;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pix;
        logic               last;
    } emit_t;

    function automatic logic [SUM_W-1:0] lane_pair(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int ch = 0; ch < 4; ch++) begin
            r[LANE_W*ch +: LANE_W] = {1'b0, a[8*ch +: 8]} + {1'b0, b[8*ch +: 8]};
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] lane_average(input logic [SUM_W-1:0] t,
                                                      input logic [SUM_W-1:0] b);
        logic [PIX_W-1:0]  r;
        logic [LANE_W:0]   s;
        r = '0;
        for (int ch = 0; ch < 4; ch++) begin
            s = {1'b0, t[LANE_W*ch +: LANE_W]} + {1'b0, b[LANE_W*ch +: LANE_W]};
            r[8*ch +: 8] = s[LANE_W:2];
        end
        return r;
    endfunction

endpackage

// File: src/mbd_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
module mbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/mbd_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbd_cell
// One mip level: position counters, held even-column pixel, pair summing
// and 2x2 averaging; hands each finished pixel to the next level's cell.
// ---------------------------------------------------------------------------
module mbd_cell #(
    parameter int LEVEL = 0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      clear_cnt,
    input  mbd_pkg::token_t           tok_in,
    output mbd_pkg::token_t           tok_out,
    input  mbd_pkg::peek_t            nb_peek,
    output mbd_pkg::peek_t            peek,
    input  logic [mbd_pkg::SUM_W-1:0] rdata,
    output mbd_pkg::mem_req_t         mem_req,
    output mbd_pkg::emit_t            emit,
    input  logic                      emit_grant,
    output logic                      done
);

    localparam int CW = mbd_pkg::CFG_W;
    localparam int LW = mbd_pkg::LVL_W;
    localparam logic [LW-1:0] NEXT_LVL  = LW'(LEVEL + 1);
    localparam logic [LW:0]   NEXT2_LVL = (LW+1)'(LEVEL + 2);

    mbd_pkg::cell_state_t state_reg, state_next;

    logic [CW-1:0]                    col_reg, col_next;
    logic [CW-1:0]                    row_reg, row_next;
    logic [mbd_pkg::PIX_W-1:0]        held_reg, held_next;
    logic [mbd_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [mbd_pkg::PIX_W-1:0]        avg_reg, avg_next;
    logic                             last_reg, last_next;
    logic [mbd_pkg::COORD_W-1:0]      ocol_reg, ocol_next;
    logic [mbd_pkg::COORD_W-1:0]      orow_reg, orow_next;
    logic [CW-1:0]                    pcw_reg, pcw_next;
    logic [CW-1:0]                    pch_reg, pch_next;
    logic [CW-1:0]                    pbase_reg, pbase_next;
    logic [LW-1:0]                    plev_reg, plev_next;
    logic                             tok_vld_reg, tok_vld_next;

    logic                      arrive;
    logic                      en;
    logic                      in_rng;
    logic                      act;
    logic                      fetch;
    logic                      store;
    logic [mbd_pkg::SUM_W-1:0] pair;
    logic [CW-1:0]             addr;
    logic [CW:0]               col_inc;
    logic [CW:0]               row_inc;
    logic                      nb_fetch;

    assign arrive = tok_in.valid && (state_reg == mbd_pkg::CELL_IDLE);
    assign en     = NEXT_LVL < tok_in.levels;
    assign in_rng = (col_reg < {tok_in.cw[CW-1:1], 1'b0}) &&
                    (row_reg < {tok_in.ch[CW-1:1], 1'b0});
    assign act    = arrive && en && in_rng;
    assign fetch  = act && col_reg[0] && row_reg[0];
    assign store  = act && col_reg[0] && !row_reg[0];
    assign pair   = mbd_pkg::lane_pair(held_reg, tok_in.pix);
    assign addr   = tok_in.base + {1'b0, col_reg[CW-1:1]};
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 1'b1;

    // will the next level finish a pixel with the one we are about to hand it
    assign nb_fetch = (NEXT2_LVL < {1'b0, plev_reg}) && nb_peek.col[0] && nb_peek.row[0] &&
                      (nb_peek.col < {pcw_reg[CW-1:1], 1'b0}) &&
                      (nb_peek.row < {pch_reg[CW-1:1], 1'b0});

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mbd_pkg::CELL_IDLE: begin
                if (fetch) begin
                    state_next = mbd_pkg::CELL_WAIT;
                end
            end
            mbd_pkg::CELL_WAIT: begin
                state_next = mbd_pkg::CELL_EMIT;
            end
            mbd_pkg::CELL_EMIT: begin
                if (emit_grant) begin
                    state_next = mbd_pkg::CELL_IDLE;
                end
            end
            default: begin
                state_next = mbd_pkg::CELL_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        held_next    = held_reg;
        sum_next     = sum_reg;
        avg_next     = avg_reg;
        last_next    = last_reg;
        ocol_next    = ocol_reg;
        orow_next    = orow_reg;
        pcw_next     = pcw_reg;
        pch_next     = pch_reg;
        pbase_next   = pbase_reg;
        plev_next    = plev_reg;
        tok_vld_next = 1'b0;

        if (arrive) begin
            if (act && !col_reg[0]) begin
                held_next = tok_in.pix;
            end
            if (fetch) begin
                sum_next   = pair;
                ocol_next  = col_reg[mbd_pkg::COORD_W:1];
                orow_next  = row_reg[mbd_pkg::COORD_W:1];
                pcw_next   = {1'b0, tok_in.cw[CW-1:1]};
                pch_next   = {1'b0, tok_in.ch[CW-1:1]};
                pbase_next = tok_in.base + {1'b0, tok_in.cw[CW-1:1]};
                plev_next  = tok_in.levels;
            end
            if ((tok_in.cw != '0) && (tok_in.ch != '0)) begin
                if (col_inc >= {1'b0, tok_in.cw}) begin
                    col_next = '0;
                    if (row_inc >= {1'b0, tok_in.ch}) begin
                        row_next = '0;
                    end else begin
                        row_next = row_inc[CW-1:0];
                    end
                end else begin
                    col_next = col_inc[CW-1:0];
                end
            end
        end

        if (state_reg == mbd_pkg::CELL_WAIT) begin
            avg_next  = mbd_pkg::lane_average(rdata, sum_reg);
            last_next = !nb_fetch;
        end

        if ((state_reg == mbd_pkg::CELL_EMIT) && emit_grant) begin
            tok_vld_next = 1'b1;
        end

        if (clear_cnt) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mbd_pkg::CELL_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            tok_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            tok_vld_reg <= tok_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg  <= held_next;
        sum_reg   <= sum_next;
        avg_reg   <= avg_next;
        last_reg  <= last_next;
        ocol_reg  <= ocol_next;
        orow_reg  <= orow_next;
        pcw_reg   <= pcw_next;
        pch_reg   <= pch_next;
        pbase_reg <= pbase_next;
        plev_reg  <= plev_next;
    end

    // outputs
    always_comb begin
        tok_out.valid  = tok_vld_reg;
        tok_out.pix    = avg_reg;
        tok_out.cw     = pcw_reg;
        tok_out.ch     = pch_reg;
        tok_out.base   = pbase_reg;
        tok_out.levels = plev_reg;

        peek.col = col_reg;
        peek.row = row_reg;

        mem_req.rd_en = fetch;
        mem_req.wr_en = store;
        mem_req.addr  = (fetch || store) ? addr : '0;
        mem_req.wdata = store ? pair : '0;

        emit.valid     = (state_reg == mbd_pkg::CELL_EMIT);
        emit.mip_level = emit.valid ? NEXT_LVL : '0;
        emit.col       = emit.valid ? ocol_reg : '0;
        emit.row       = emit.valid ? orow_reg : '0;
        emit.pix       = emit.valid ? avg_reg : '0;
        emit.last      = emit.valid && last_reg;

        done = arrive && !fetch;
    end

endmodule

// File: src/mipmap_box_downsampler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mipmap_box_downsampler
// Builds a full mip chain from a raster-order RGBA8 stream with 2x2 box
// averaging.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries level-zero pixels in raster order. m_* returns every finished
//   pixel of level 1 and up with its level, column and row, lowest level
//   first; m_last marks the final result caused by one input pixel.
//   cfg_* writes image_width (index 0) or image_height (index 1); a write
//   restarts the frame. Write only while no pixel is in flight.
// Flow:
//   one cell per level; a pixel walks up the chain one level at a time.
//   s_ready stays low until the pixel reaches a level where it finishes no
//   higher pixel, so a new input is taken only after the last is through.
//   Each result passes the pair-sum RAM read, the average and the hand-off
//   to the output register. The single-port-per-side pair-sum RAM is shared
//   by all levels and sets this one-level-at-a-time flow.
// Reset and stall:
//   reset clears counters, sets both sizes to 4096 and empties the chain.
//   A result waits in the output register while m_ready is low; the next
//   input is still taken, and the chain stalls only when a second result is
//   ready to leave while the first is still held.
// ---------------------------------------------------------------------------
module mipmap_box_downsampler #(
    parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_LEVELS = mbd_pkg::DEF_MAX_LEVELS
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mbd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [mbd_pkg::CFG_W-1:0]   cfg_wdata,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mbd_pkg::PIX_W-1:0]   s_pixel_in,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mbd_pkg::LVL_W-1:0]   m_mip_level,
    output logic [mbd_pkg::COORD_W-1:0] m_col,
    output logic [mbd_pkg::COORD_W-1:0] m_row,
    output logic [mbd_pkg::PIX_W-1:0]   m_pixel_out,
    output logic                        m_last
);

    localparam int CW = mbd_pkg::CFG_W;
    localparam int LW = mbd_pkg::LVL_W;
    localparam int AW = $clog2(MAX_WIDTH);

    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] height_reg, height_next;
    logic          busy_reg, busy_next;
    logic          tok0_vld_reg;
    logic [mbd_pkg::PIX_W-1:0] tok0_pix_reg;
    logic [CW-1:0] tok0_cw_reg;
    logic [CW-1:0] tok0_ch_reg;
    logic [LW-1:0] tok0_lev_reg;

    logic          out_vld_reg, out_vld_next;
    mbd_pkg::emit_t out_reg;

    logic          cfg_wr;
    logic          clear_cnt;
    logic          s_xfer;
    logic [CW-1:0] cw_clamp;
    logic [CW-1:0] ch_clamp;
    logic [CW-1:0] min_size;
    logic [CW-1:0] min_m1;
    logic [LW-1:0] log_ceil;
    logic [LW:0]   lev_raw;
    logic [LW-1:0] levels;

    mbd_pkg::token_t   tok     [MAX_LEVELS+1];
    mbd_pkg::peek_t    peek    [MAX_LEVELS+1];
    mbd_pkg::mem_req_t mem_req [MAX_LEVELS];
    mbd_pkg::emit_t    emit    [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] done_vec;
    logic [MAX_LEVELS-1:0] emit_vec;
    logic [MAX_LEVELS-1:0] mem_vec;

    mbd_pkg::mem_req_t mem_any;
    mbd_pkg::emit_t    emit_any;
    logic              emit_grant;
    logic              done_any;
    logic [mbd_pkg::SUM_W-1:0] rdata;

    // configuration
    assign cfg_ready = !busy_reg;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        clear_cnt   = 1'b0;
        if (cfg_wr) begin
            unique case (cfg_index)
                mbd_pkg::REG_IMAGE_WIDTH: begin
                    width_next = cfg_wdata;
                    clear_cnt  = 1'b1;
                end
                mbd_pkg::REG_IMAGE_HEIGHT: begin
                    height_next = cfg_wdata;
                    clear_cnt   = 1'b1;
                end
                default: begin
                    clear_cnt = 1'b0;
                end
            endcase
        end
    end

    // clamped sizes and chain length
    always_comb begin
        if (width_reg == '0) begin
            cw_clamp = CW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            cw_clamp = CW'(MAX_WIDTH);
        end else begin
            cw_clamp = width_reg;
        end
        if (height_reg == '0) begin
            ch_clamp = CW'(1);
        end else if (32'(height_reg) > MAX_WIDTH) begin
            ch_clamp = CW'(MAX_WIDTH);
        end else begin
            ch_clamp = height_reg;
        end
        min_size = (cw_clamp < ch_clamp) ? cw_clamp : ch_clamp;
        min_m1   = min_size - 1'b1;
        // ceil(log2(min)) is one past the top set bit of min - 1
        log_ceil = '0;
        for (int i = 0; i < CW; i++) begin
            if (min_m1[i]) begin
                log_ceil = LW'(i + 1);
            end
        end
        lev_raw = {1'b0, log_ceil} + 1'b1;
        if (32'(lev_raw) > MAX_LEVELS) begin
            levels = LW'(MAX_LEVELS);
        end else begin
            levels = lev_raw[LW-1:0];
        end
    end

    // input side
    assign s_ready = !busy_reg;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        busy_next = busy_reg;
        if (s_xfer) begin
            busy_next = 1'b1;
        end else if (done_any) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= mbd_pkg::RESET_SIZE;
            height_reg   <= mbd_pkg::RESET_SIZE;
            busy_reg     <= 1'b0;
            tok0_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            busy_reg     <= busy_next;
            tok0_vld_reg <= s_xfer;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            tok0_pix_reg <= s_pixel_in;
            tok0_cw_reg  <= cw_clamp;
            tok0_ch_reg  <= ch_clamp;
            tok0_lev_reg <= levels;
        end
        if (emit_grant) begin
            out_reg <= emit_any;
        end
    end

    always_comb begin
        tok[0].valid  = tok0_vld_reg;
        tok[0].pix    = tok0_pix_reg;
        tok[0].cw     = tok0_cw_reg;
        tok[0].ch     = tok0_ch_reg;
        tok[0].base   = '0;
        tok[0].levels = tok0_lev_reg;
    end

    // the top cell has no neighbor that could finish a pixel
    assign peek[MAX_LEVELS] = '0;

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
        mbd_cell #(
            .LEVEL (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .clear_cnt  (clear_cnt),
            .tok_in     (tok[g]),
            .tok_out    (tok[g+1]),
            .nb_peek    (peek[g+1]),
            .peek       (peek[g]),
            .rdata      (rdata),
            .mem_req    (mem_req[g]),
            .emit       (emit[g]),
            .emit_grant (emit_grant),
            .done       (done_vec[g])
        );
        assign emit_vec[g] = emit[g].valid;
        assign mem_vec[g]  = mem_req[g].rd_en || mem_req[g].wr_en;
    end

    // only one cell holds the pixel at a time, so requests merge by OR
    always_comb begin
        mem_any  = '0;
        emit_any = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            mem_any  = mem_any | mem_req[i];
            emit_any = emit_any | emit[i];
        end
    end

    assign done_any   = |done_vec;
    assign emit_grant = emit_any.valid && (!out_vld_reg || m_ready);

    always_comb begin
        out_vld_next = out_vld_reg;
        if (emit_grant) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    mbd_ram #(
        .WIDTH (mbd_pkg::SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_pair_ram (
        .aclk  (aclk),
        .we    (mem_any.wr_en),
        .waddr (AW'(mem_any.addr)),
        .wdata (mem_any.wdata),
        .re    (mem_any.rd_en),
        .raddr (AW'(mem_any.addr)),
        .rdata (rdata)
    );

    assign m_valid     = out_vld_reg;
    assign m_mip_level = out_reg.mip_level;
    assign m_col       = out_reg.col;
    assign m_row       = out_reg.row;
    assign m_pixel_out = out_reg.pix;
    assign m_last      = out_reg.last;

    // checks
    a_one_emitter: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(emit_vec))
        else $error("more than one level offers a result");

    a_one_ram_user: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(mem_vec))
        else $error("more than one level uses the pair-sum ram");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_any |-> busy_reg)
        else $error("pixel finished while the chain was idle");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !tok[MAX_LEVELS].valid)
        else $error("pixel handed past the top level");

    a_emit_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_any.valid |-> busy_reg)
        else $error("result offered with no pixel in flight");

endmodule
